// ===== src/etam_pkg.sv =====
// etam_pkg: shared types and constants for the emg / tilt activity monitor
// used by the config, front, queue, back and top-level modules
`timescale 1ns / 1ps
`default_nettype none

package etam_pkg;

  typedef enum logic [1:0] {
    MODE_EMG   = 2'd0,
    MODE_ACCEL = 2'd1,
    MODE_TICK  = 2'd2,
    MODE_WAKE  = 2'd3
  } etam_mode_t;

  typedef enum logic [2:0] {
    KIND_NONE  = 3'd0,
    KIND_EMG   = 3'd1,
    KIND_DIR   = 3'd2,
    KIND_SLEEP = 3'd3,
    KIND_WOKE  = 3'd4
  } etam_kind_t;

  typedef enum logic [1:0] {
    DIR_CENTRE = 2'd0,
    DIR_RIGHT  = 2'd1,
    DIR_LEFT   = 2'd2
  } etam_dir_t;

  localparam logic [2:0] REG_EMG_THRESHOLD = 3'd0;
  localparam logic [2:0] REG_EMG_CONFIRM   = 3'd1;
  localparam logic [2:0] REG_SLEEP_AFTER   = 3'd2;
  localparam logic [2:0] REG_CENTER_TAN_SQ = 3'd3;
  localparam logic [2:0] REG_MIN_YZ_SQUARE = 3'd4;

  localparam logic [9:0]  RST_EMG_THRESHOLD = 10'd700;
  localparam logic [3:0]  RST_EMG_CONFIRM   = 4'd3;
  localparam logic [7:0]  RST_SLEEP_AFTER   = 8'd10;
  localparam logic [15:0] RST_CENTER_TAN_SQ = 16'd4705;
  localparam logic [31:0] RST_MIN_YZ_SQUARE = 32'd268;

  typedef struct packed {
    logic [9:0]  emg_threshold;
    logic [3:0]  emg_confirm_count;
    logic [7:0]  sleep_after_seconds;
    logic [15:0] center_tan_sq_q16;
    logic [31:0] min_yz_square;
  } etam_cfg_t;

  // classified request handed from front to back
  typedef struct packed {
    etam_mode_t mode;
    logic [9:0] emg_sample;
    etam_dir_t  dir;
  } etam_item_t;

  typedef struct packed {
    etam_kind_t report_kind;
    logic [9:0] emg_level;
    etam_dir_t  direction;
    logic       emg_active_flag;
    logic       emg_changed;
    logic       sleeping_flag;
  } etam_result_t;

endpackage

`default_nettype wire

// ===== src/etam_cfg.sv =====
// etam_cfg: configuration register file with reset defaults
// depends on etam_pkg
`timescale 1ns / 1ps
`default_nettype none

module etam_cfg (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_wr_en,
  input  wire logic [2:0]          cfg_index,
  input  wire logic [31:0]         cfg_wdata,
  output etam_pkg::etam_cfg_t      cfg
);
  import etam_pkg::*;

  etam_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.emg_threshold       <= RST_EMG_THRESHOLD;
      cfg_r.emg_confirm_count   <= RST_EMG_CONFIRM;
      cfg_r.sleep_after_seconds <= RST_SLEEP_AFTER;
      cfg_r.center_tan_sq_q16   <= RST_CENTER_TAN_SQ;
      cfg_r.min_yz_square       <= RST_MIN_YZ_SQUARE;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_EMG_THRESHOLD: cfg_r.emg_threshold       <= cfg_wdata[9:0];
        REG_EMG_CONFIRM:   cfg_r.emg_confirm_count   <= cfg_wdata[3:0];
        REG_SLEEP_AFTER:   cfg_r.sleep_after_seconds <= cfg_wdata[7:0];
        REG_CENTER_TAN_SQ: cfg_r.center_tan_sq_q16   <= cfg_wdata[15:0];
        REG_MIN_YZ_SQUARE: cfg_r.min_yz_square       <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ===== src/etam_front.sv =====
// etam_front: accepts input requests and classifies tilt over four steps
// (squares, y/z sum, tangent product, compare); depends on etam_pkg
`timescale 1ns / 1ps
`default_nettype none

module etam_front (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire etam_pkg::etam_cfg_t cfg,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire etam_pkg::etam_mode_t in_mode,
  input  wire logic [9:0]          in_emg_sample,
  input  wire logic [15:0]         in_accel_x,
  input  wire logic [15:0]         in_accel_y,
  input  wire logic [15:0]         in_accel_z,
  output logic                     push,
  output etam_pkg::etam_item_t     push_item,
  input  wire logic                q_full
);
  import etam_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SQ,
    PH_SUM,
    PH_MUL,
    PH_CMP
  } phase_t;

  phase_t      phase_r;
  etam_mode_t  mode_r;
  logic [9:0]  sample_r;
  logic signed [15:0] x_r, y_r, z_r;
  logic [31:0] x2_r, y2_r, z2_r, yz_r;
  logic [47:0] prod_r;
  logic        near_r;

  logic signed [31:0] xe, ye, ze;
  logic               accept;
  logic               tilted;
  etam_dir_t          dir;

  assign xe = 32'(x_r);
  assign ye = 32'(y_r);
  assign ze = 32'(z_r);

  assign in_ready = (phase_r == PH_IDLE) || (phase_r == PH_CMP && !q_full);
  assign accept   = in_valid && in_ready;
  assign push     = (phase_r == PH_CMP) && !q_full;

  assign tilted = {x2_r, 16'd0} > prod_r;

  always_comb begin
    dir = DIR_CENTRE;
    if (!near_r && tilted) begin
      dir = x_r[15] ? DIR_RIGHT : DIR_LEFT;
    end
  end

  assign push_item.mode       = mode_r;
  assign push_item.emg_sample = sample_r;
  assign push_item.dir        = dir;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
    end else begin
      case (phase_r)
        PH_IDLE: if (accept) phase_r <= PH_SQ;
        PH_SQ:   phase_r <= PH_SUM;
        PH_SUM:  phase_r <= PH_MUL;
        PH_MUL:  phase_r <= PH_CMP;
        PH_CMP: begin
          if (accept) begin
            phase_r <= PH_SQ;
          end else if (push) begin
            phase_r <= PH_IDLE;
          end
        end
        default: phase_r <= PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r   <= in_mode;
      sample_r <= in_emg_sample;
      x_r      <= $signed(in_accel_x);
      y_r      <= $signed(in_accel_y);
      z_r      <= $signed(in_accel_z);
    end
    if (phase_r == PH_SQ) begin
      x2_r <= $unsigned(xe * xe);
      y2_r <= $unsigned(ye * ye);
      z2_r <= $unsigned(ze * ze);
    end
    if (phase_r == PH_SUM) begin
      yz_r <= y2_r + z2_r;
    end
    if (phase_r == PH_MUL) begin
      prod_r <= 48'(cfg.center_tan_sq_q16) * 48'(yz_r);
      near_r <= yz_r <= cfg.min_yz_square;
    end
  end

endmodule

`default_nettype wire

// ===== src/etam_queue.sv =====
// etam_queue: two-entry queue of classified requests between front and back
// depends on etam_pkg
`timescale 1ns / 1ps
`default_nettype none

module etam_queue (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire etam_pkg::etam_item_t push_item,
  output logic                     full,
  input  wire logic                pop,
  output logic                     not_empty,
  output etam_pkg::etam_item_t     head
);
  import etam_pkg::*;

  etam_item_t mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign head      = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== src/etam_back.sv =====
// etam_back: applies emg, tilt, idle and sleep state updates and holds the result
// register; depends on etam_pkg
`timescale 1ns / 1ps
`default_nettype none

module etam_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire etam_pkg::etam_cfg_t cfg,
  input  wire logic                q_not_empty,
  input  wire etam_pkg::etam_item_t q_head,
  output logic                     pop,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output etam_pkg::etam_result_t   out_result
);
  import etam_pkg::*;

  logic         sleeping_r, sleeping_nxt;
  logic [3:0]   hits_r, hits_nxt;
  logic         active_r, active_nxt;
  logic [7:0]   idle_r, idle_nxt;
  etam_dir_t    last_r, last_nxt;
  logic         out_valid_r;
  etam_result_t result_r, result_nxt;

  logic [4:0]   hit_inc;
  logic [3:0]   hit_dec;
  logic [8:0]   tick_inc;

  assign pop        = q_not_empty && (!out_valid_r || out_ready);
  assign out_valid  = out_valid_r;
  assign out_result = result_r;

  assign hit_inc  = {1'b0, hits_r} + 5'd1;
  assign hit_dec  = (hits_r != 4'd0) ? hits_r - 4'd1 : hits_r;
  assign tick_inc = {1'b0, idle_r} + 9'd1;

  always_comb begin
    sleeping_nxt = sleeping_r;
    hits_nxt     = hits_r;
    active_nxt   = active_r;
    idle_nxt     = idle_r;
    last_nxt     = last_r;
    result_nxt.report_kind = KIND_NONE;
    result_nxt.emg_level   = 10'd0;
    result_nxt.direction   = DIR_CENTRE;
    case (q_head.mode)
      MODE_WAKE: begin
        sleeping_nxt = 1'b0;
        idle_nxt     = 8'd0;
        last_nxt     = DIR_CENTRE;
        result_nxt.report_kind = KIND_WOKE;
      end
      default: begin
        if (!sleeping_r) begin
          if (q_head.mode == MODE_EMG) begin
            if (q_head.emg_sample > cfg.emg_threshold) begin
              if (hit_inc >= {1'b0, cfg.emg_confirm_count}) begin
                active_nxt = 1'b1;
                hits_nxt   = cfg.emg_confirm_count;
              end else begin
                hits_nxt = hit_inc[3:0];
              end
            end else begin
              hits_nxt = hit_dec;
              if (hit_dec == 4'd0) active_nxt = 1'b0;
            end
            if (active_nxt) begin
              result_nxt.report_kind = KIND_EMG;
              result_nxt.emg_level   = q_head.emg_sample;
            end
          end else if (!active_r) begin
            if (q_head.mode == MODE_ACCEL) begin
              result_nxt.report_kind = KIND_DIR;
              result_nxt.direction   = q_head.dir;
              if (q_head.dir != last_r) begin
                idle_nxt = 8'd0;
                last_nxt = q_head.dir;
              end
            end else begin
              if (tick_inc >= {1'b0, cfg.sleep_after_seconds}) begin
                sleeping_nxt = 1'b1;
                idle_nxt     = 8'd0;
                result_nxt.report_kind = KIND_SLEEP;
              end else begin
                idle_nxt = tick_inc[7:0];
              end
            end
          end
          if (active_nxt) begin
            idle_nxt = 8'd0;
            last_nxt = DIR_CENTRE;
          end
        end
      end
    endcase
    result_nxt.emg_active_flag = active_nxt;
    result_nxt.emg_changed     = active_nxt != active_r;
    result_nxt.sleeping_flag   = sleeping_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sleeping_r  <= 1'b0;
      hits_r      <= 4'd0;
      active_r    <= 1'b0;
      idle_r      <= 8'd0;
      last_r      <= DIR_CENTRE;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        sleeping_r <= sleeping_nxt;
        hits_r     <= hits_nxt;
        active_r   <= active_nxt;
        idle_r     <= idle_nxt;
        last_r     <= last_nxt;
      end
      if (pop) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) result_r <= result_nxt;
  end

endmodule

`default_nettype wire

// ===== src/emg_tilt_activity_monitor.sv =====
// emg_tilt_activity_monitor: top level joining config, front, queue and back
// depends on etam_pkg, etam_cfg, etam_front, etam_queue, etam_back
//
//   port group  dir  contents
//   in_*        in   tuser: mode; tdata: emg_sample, accel_x, accel_y, accel_z
//   out_*       out  tuser: report_kind; tdata: emg_level, direction, flags
//   cfg_*       in   write enable, register index, 32-bit write data
//
// the front takes a new request while idle or in its compare step, when the queue is not full,
// so a request is accepted only once the last has passed the four classify steps (squares,
// y/z sum, tangent product, compare); the queue hop and the back's result register lie between
// the front and out_tvalid; a two-entry queue lets the front keep classifying while out_tready is low
// rst_n is synchronous, active low, and clears all control state
`timescale 1ns / 1ps
`default_nettype none

module emg_tilt_activity_monitor (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // emg_sample, accel_x, accel_y, accel_z, zero pad
  input  wire logic [1:0]  in_tuser,   // mode
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // emg_level, direction, emg_active_flag,
                                       // emg_changed, sleeping_flag, zero pad
  output logic [2:0]       out_tuser,  // report_kind
  input  wire logic        cfg_wr_en,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_wdata
);
  import etam_pkg::*;

  etam_cfg_t    cfg;
  logic         push;
  etam_item_t   push_item;
  logic         q_full;
  logic         pop;
  logic         q_not_empty;
  etam_item_t   q_head;
  etam_result_t result;

  etam_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  etam_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .in_valid      (in_tvalid),
    .in_ready      (in_tready),
    .in_mode       (etam_mode_t'(in_tuser)),
    .in_emg_sample (in_tdata[9:0]),
    .in_accel_x    (in_tdata[25:10]),
    .in_accel_y    (in_tdata[41:26]),
    .in_accel_z    (in_tdata[57:42]),
    .push          (push),
    .push_item     (push_item),
    .q_full        (q_full)
  );

  etam_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  etam_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .pop         (pop),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_result  (result)
  );

  assign out_tuser = result.report_kind;
  assign out_tdata = {1'b0, result.sleeping_flag, result.emg_changed,
                      result.emg_active_flag, result.direction, result.emg_level};

endmodule

`default_nettype wire

// ===== tb/tb_emg_tilt_activity_monitor.sv =====
// tb_emg_tilt_activity_monitor: self-checking bench for the emg / tilt activity monitor
// predicts every report in a scoreboard class and checks it against the out_* stream
// depends on etam_pkg and emg_tilt_activity_monitor
`timescale 1ns / 1ps

module tb_emg_tilt_activity_monitor;
  import etam_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  class activity_tracker;
    logic [9:0]  emg_thr      = RST_EMG_THRESHOLD;
    logic [3:0]  confirm_hits = RST_EMG_CONFIRM;
    logic [7:0]  sleep_limit  = RST_SLEEP_AFTER;
    logic [15:0] tan_sq       = RST_CENTER_TAN_SQ;
    logic [31:0] min_yz       = RST_MIN_YZ_SQUARE;

    bit        asleep;
    int        emg_hits;
    bit        emg_on;
    int        idle_secs;
    etam_dir_t last_dir = DIR_CENTRE;

    etam_result_t pending_reports[$];
    int mismatches;
    int requests_taken;
    int kind_seen[5];

    function void set_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        REG_EMG_THRESHOLD: emg_thr = val[9:0];
        REG_EMG_CONFIRM:   confirm_hits = val[3:0];
        REG_SLEEP_AFTER:   sleep_limit = val[7:0];
        REG_CENTER_TAN_SQ: tan_sq = val[15:0];
        REG_MIN_YZ_SQUARE: min_yz = val;
        default: ;
      endcase
    endfunction

    function etam_dir_t classify_tilt(logic [15:0] ax, logic [15:0] ay, logic [15:0] az);
      longint sx, sy, sz, x_sq, yz_sq;
      sx = longint'($signed(ax));
      sy = longint'($signed(ay));
      sz = longint'($signed(az));
      x_sq = sx * sx;
      yz_sq = sy * sy + sz * sz;
      if (yz_sq <= longint'(min_yz)) return DIR_CENTRE;
      // the limit angle itself still counts as centre
      if ((x_sq <<< 16) <= longint'(tan_sq) * yz_sq) return DIR_CENTRE;
      return (sx < 0) ? DIR_RIGHT : DIR_LEFT;
    endfunction

    function void take_request(etam_mode_t mode, logic [9:0] sample,
                               logic [15:0] ax, logic [15:0] ay, logic [15:0] az);
      etam_result_t r;
      etam_dir_t    d;
      bit           was_on;
      int           h, t;
      r = '0;
      r.report_kind = KIND_NONE;
      r.direction = DIR_CENTRE;
      was_on = emg_on;
      requests_taken++;
      if (mode == MODE_WAKE) begin
        asleep = 1'b0;
        idle_secs = 0;
        last_dir = DIR_CENTRE;
        r.report_kind = KIND_WOKE;
      end else if (!asleep) begin
        if (mode == MODE_EMG) begin
          if (sample > emg_thr) begin
            h = emg_hits + 1;
            if (h >= int'(confirm_hits)) begin
              emg_on = 1'b1;
              h = int'(confirm_hits);
            end
            emg_hits = h & 15;
          end else begin
            if (emg_hits > 0) emg_hits--;
            if (emg_hits == 0) emg_on = 1'b0;
          end
          if (emg_on) begin
            r.report_kind = KIND_EMG;
            r.emg_level = sample;
          end
        end else if (!emg_on) begin
          if (mode == MODE_ACCEL) begin
            d = classify_tilt(ax, ay, az);
            r.report_kind = KIND_DIR;
            r.direction = d;
            if (d != last_dir) begin
              idle_secs = 0;
              last_dir = d;
            end
          end else begin
            t = idle_secs + 1;
            if (t >= int'(sleep_limit)) begin
              asleep = 1'b1;
              idle_secs = 0;
              r.report_kind = KIND_SLEEP;
            end else begin
              idle_secs = t & 255;
            end
          end
        end
        if (emg_on) begin
          idle_secs = 0;
          last_dir = DIR_CENTRE;
        end
      end
      r.emg_active_flag = emg_on;
      r.emg_changed = (emg_on != was_on);
      r.sleeping_flag = asleep;
      pending_reports.push_back(r);
    endfunction

    function void check_report(logic [2:0] kind, logic [15:0] data);
      etam_result_t want;
      if (pending_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result at %0t: kind %0d data %h", $time, kind, data);
        return;
      end
      want = pending_reports.pop_front();
      kind_seen[int'(want.report_kind)]++;
      if (kind !== want.report_kind || data[9:0] !== want.emg_level ||
          data[11:10] !== want.direction || data[12] !== want.emg_active_flag ||
          data[13] !== want.emg_changed || data[14] !== want.sleeping_flag) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch at %0t: expected kind %0d level %0d dir %0d act %b chg %b slp %b",
                   $time, want.report_kind, want.emg_level, want.direction,
                   want.emg_active_flag, want.emg_changed, want.sleeping_flag);
          $display("  got kind %0d level %0d dir %0d act %b chg %b slp %b",
                   kind, data[9:0], data[11:10], data[12], data[13], data[14]);
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;   // emg_sample, accel_x, accel_y, accel_z, zero pad
  logic [1:0]  in_tuser = '0;   // mode
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;       // emg_level, direction, emg_active_flag, emg_changed,
                                // sleeping_flag, zero pad
  logic [2:0]  out_tuser;       // report_kind
  logic        cfg_wr_en = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_wdata = '0;

  activity_tracker tracker = new();

  int cycle_count = 0;
  int rx_stall_pct = 0;
  int rx_hold = 0;
  int burst_left = 0;
  bit gaps_on = 1'b0;
  bit emg_hot = 1'b0;
  int settings_used = 0;

  emg_tilt_activity_monitor dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d reports outstanding",
               cycle_count, tracker.pending_reports.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // receiver: random stalls plus the odd long hold
  always @(negedge clk) begin
    if (rx_hold != 0) begin
      rx_hold <= rx_hold - 1;
      out_tready <= 1'b0;
    end else if (rx_stall_pct != 0 && $urandom_range(0, 99) < 3) begin
      rx_hold <= $urandom_range(2, 12);
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      tracker.check_report(out_tuser, out_tdata);
  end

  task automatic send_request(etam_mode_t mode, logic [9:0] sample,
                              logic [15:0] ax, logic [15:0] ay, logic [15:0] az);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = gaps_on ? $urandom_range(0, 8) : 0;
      if (gap > 0) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser <= mode;
    in_tdata <= {6'b0, az, ay, ax, sample};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    tracker.take_request(mode, sample, ax, ay, az);
  endtask

  task automatic drain_reports();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (tracker.pending_reports.size() != 0) @(posedge clk);
    // leave margin after the last report is taken
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    tracker.set_reg(idx, val);
  endtask

  task automatic apply_settings(logic [9:0] thr, logic [3:0] confirm, logic [7:0] sleep_s,
                                logic [15:0] tan_q16, logic [31:0] yz_min);
    int stall_levels[6];
    stall_levels = '{0, 30, 70, 15, 50, 0};
    drain_reports();
    write_reg(REG_EMG_THRESHOLD, {22'b0, thr});
    write_reg(REG_EMG_CONFIRM, {28'b0, confirm});
    write_reg(REG_SLEEP_AFTER, {24'b0, sleep_s});
    write_reg(REG_CENTER_TAN_SQ, {16'b0, tan_q16});
    write_reg(REG_MIN_YZ_SQUARE, yz_min);
    rx_stall_pct = stall_levels[settings_used % 6];
    gaps_on = (settings_used % 3) != 0;
    settings_used++;
  endtask

  function automatic logic [9:0] emg_value(bit hit);
    if ($urandom_range(0, 9) == 0) return 10'($urandom);
    if (hit && tracker.emg_thr != 10'd1023)
      return 10'($urandom_range(tracker.emg_thr + 1, 1023));
    if (!hit) return 10'($urandom_range(0, tracker.emg_thr));
    return 10'd1023;
  endfunction

  task automatic tilt_vector(output logic [15:0] ax, output logic [15:0] ay,
                             output logic [15:0] az);
    logic [15:0] corner[4];
    corner = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff};
    ax = 16'($urandom);
    ay = 16'($urandom);
    az = 16'($urandom);
    case ($urandom_range(0, 5))
      0: begin
        ay = 16'(int'($urandom_range(0, 30)) - 15);
        az = 16'(int'($urandom_range(0, 30)) - 15);
      end
      1: begin
        ax = corner[$urandom_range(0, 3)];
        ay = corner[$urandom_range(0, 3)];
        az = corner[$urandom_range(0, 3)];
      end
      2: ax = 16'(int'($urandom_range(0, 16000)) - 8000);
      default: ;
    endcase
  endtask

  task automatic random_request();
    int pick;
    logic [9:0] s;
    logic [15:0] ax, ay, az;
    pick = $urandom_range(0, 99);
    s = 10'($urandom);
    ax = 16'($urandom);
    ay = 16'($urandom);
    az = 16'($urandom);
    if ($urandom_range(0, 9) == 0) emg_hot = !emg_hot;
    if (pick < 38) begin
      s = emg_value($urandom_range(0, 99) < (emg_hot ? 85 : 15));
      send_request(MODE_EMG, s, ax, ay, az);
    end else if (pick < 75) begin
      tilt_vector(ax, ay, az);
      send_request(MODE_ACCEL, s, ax, ay, az);
    end else if (pick < 93) begin
      send_request(MODE_TICK, s, ax, ay, az);
    end else begin
      send_request(MODE_WAKE, s, ax, ay, az);
    end
  endtask

  task automatic random_phase(int count);
    int n, run;
    bit paused;
    n = 0;
    paused = 1'b0;
    while (n < count) begin
      if ($urandom_range(0, 99) < 5) begin
        // tick runs to walk the idle count up to sleep
        run = $urandom_range(2, 20);
        repeat (run)
          send_request(MODE_TICK, 10'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        n += run;
      end else begin
        random_request();
        n++;
      end
      if (!paused && n >= count / 2) begin
        drain_reports();
        paused = 1'b1;
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    apply_settings(RST_EMG_THRESHOLD, RST_EMG_CONFIRM, RST_SLEEP_AFTER,
                   RST_CENTER_TAN_SQ, RST_MIN_YZ_SQUARE);
    send_request(MODE_TICK, 10'd0, 16'd0, 16'd0, 16'd0);
    send_request(MODE_ACCEL, 10'd0, 16'd0, 16'd0, 16'd16384);
    send_request(MODE_ACCEL, 10'd0, 16'hc000, 16'd0, 16'd1000);
    send_request(MODE_ACCEL, 10'd0, 16'h7fff, 16'h7fff, 16'h7fff);
    send_request(MODE_ACCEL, 10'd0, 16'h8000, 16'h8000, 16'h8000);
    // y and z too small to tell
    send_request(MODE_ACCEL, 10'd0, 16'd100, 16'd5, 16'hfffb);
    // exactly on the centre limit, then just past it both ways
    send_request(MODE_ACCEL, 10'd0, 16'd4705, 16'd12288, 16'd12544);
    send_request(MODE_ACCEL, 10'd0, 16'd4706, 16'd12288, 16'd12544);
    send_request(MODE_ACCEL, 10'd0, 16'(-4706), 16'd12288, 16'd12544);
    repeat (3) send_request(MODE_EMG, 10'd1023, 16'd0, 16'd0, 16'd0);
    // tilt and tick ignored while emg active
    send_request(MODE_ACCEL, 10'd0, 16'h7fff, 16'd0, 16'd1);
    send_request(MODE_TICK, 10'd0, 16'd0, 16'd0, 16'd0);
    send_request(MODE_EMG, 10'd700, 16'd0, 16'd0, 16'd0);
    send_request(MODE_EMG, 10'd0, 16'd0, 16'd0, 16'd0);
    send_request(MODE_EMG, 10'd0, 16'd0, 16'd0, 16'd0);
    send_request(MODE_EMG, 10'd701, 16'd0, 16'd0, 16'd0);
    send_request(MODE_WAKE, 10'd0, 16'd0, 16'd0, 16'd0);
    random_phase(200);

    // zero confirm count and zero sleep limit
    apply_settings(10'd0, 4'd0, 8'd0, 16'd0, 32'd0);
    send_request(MODE_EMG, 10'd1, 16'd0, 16'd0, 16'd0);
    send_request(MODE_EMG, 10'd0, 16'd0, 16'd0, 16'd0);
    send_request(MODE_TICK, 10'd0, 16'd0, 16'd0, 16'd0);
    send_request(MODE_EMG, 10'd1023, 16'd0, 16'd0, 16'd0);
    send_request(MODE_ACCEL, 10'd0, 16'h7fff, 16'd3, 16'd3);
    send_request(MODE_TICK, 10'd0, 16'd0, 16'd0, 16'd0);
    send_request(MODE_WAKE, 10'd0, 16'd0, 16'd0, 16'd0);
    random_phase(200);

    apply_settings(10'd1023, 4'd15, 8'd255, 16'hffff, 32'hffff_ffff);
    random_phase(200);
    apply_settings(10'd512, 4'd1, 8'd1, 16'd4705, 32'd268);
    random_phase(200);
    apply_settings(10'($urandom), 4'($urandom_range(1, 15)), 8'($urandom_range(1, 12)),
                   16'($urandom), 32'($urandom_range(0, 200000)));
    random_phase(200);
    apply_settings(RST_EMG_THRESHOLD, RST_EMG_CONFIRM, RST_SLEEP_AFTER,
                   RST_CENTER_TAN_SQ, RST_MIN_YZ_SQUARE);
    random_phase(200);

    drain_reports();
    $display("run covered %0d requests under %0d register settings in %0d cycles",
             tracker.requests_taken, settings_used, cycle_count);
    $display("reports seen: %0d quiet, %0d emg level, %0d direction, %0d sleep, %0d wake",
             tracker.kind_seen[0], tracker.kind_seen[1], tracker.kind_seen[2],
             tracker.kind_seen[3], tracker.kind_seen[4]);
    if (tracker.mismatches == 0 && tracker.pending_reports.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches, %0d reports missing",
               tracker.mismatches, tracker.pending_reports.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
